[hw/rtl/jssp_pkg.sv]
// shared types and codes of the job scheduler
`timescale 1ns / 1ps

package jssp_pkg;

  // width of the time counter and of the reported statistics
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned STAT_BITS = 16;

  // request kinds carried on the input tuser
  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  // configuration register indexes
  localparam logic REG_KEY_SELECT = 1'b0;
  localparam logic REG_PREEMPT    = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FREE_SCAN,
    ST_TICK_SCAN,
    ST_CUR_READ,
    ST_CUR_CAP,
    ST_PICKED,
    ST_UPDATE,
    ST_WAIT,
    ST_RESULT
  } state_e;

endpackage

[hw/rtl/jssp_slot_ram.sv]
// single write port, single registered read port slot table memory
`timescale 1ns / 1ps

module jssp_slot_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

[hw/rtl/job_scheduler_sjf_priority_unit.sv]
// job scheduler top level: slot table, key scan sequencer and result register
//
// Usage:
//   s_axis carries one request per transfer; tuser selects an arrival (0) or
//   a time tick (1), tdata holds job_id, burst_length, job_priority.
//   m_axis returns exactly one result per request in tdata.
//   cfg_we_i writes key_select (index 0) or preempt_enable (index 1) at once;
//   write only while no request is in flight.
// Sequence from the input transfer to m_axis_tvalid:
//   arrival: the one-slot-a-cycle free slot search, then ST_RESULT.
//   tick with a running job kept (no preemption): ST_CUR_READ, ST_CUR_CAP,
//   ST_UPDATE, ST_RESULT. tick with a choice: the key scan over all slots,
//   done by the one key comparator that visits every slot through the single
//   registered read port of the slot memory; a completion adds ST_WAIT.
//   one request is handled at a time; s_axis_tready is high again in the
//   cycle the result appears.
// Reset:
//   clears the valid bits, the running job, the time and both registers.
// Stall:
//   a waiting result stays in the output register; a new request is still
//   taken, and its result waits until the previous one has gone.
`timescale 1ns / 1ps

module job_scheduler_sjf_priority_unit
  import jssp_pkg::*;
#(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned ID_BITS    = 8,
  parameter int unsigned BURST_BITS = 10,
  parameter int unsigned PRIO_BITS  = 4
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // job_id, burst_length, job_priority from bit 0 up, zero filled
  input  logic [((ID_BITS+BURST_BITS+PRIO_BITS+7)/8)*8-1:0] s_axis_tdata,
  // req_type
  input  logic s_axis_tuser,

  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // rejected, busy_res, running_id, finished, finished_id, wait_time,
  // turnaround_time from bit 0 up, zero filled
  output logic [((3+2*ID_BITS+2*16+7)/8)*8-1:0] m_axis_tdata,

  input  logic cfg_we_i,
  input  logic cfg_addr_i,
  input  logic cfg_wdata_i
);

  localparam int unsigned AW       = $clog2(SLOTS);
  localparam int unsigned IW       = $clog2(SLOTS + 1);
  localparam int unsigned KEY_BITS = (BURST_BITS > PRIO_BITS) ? BURST_BITS : PRIO_BITS;
  localparam int unsigned OUT_W    = ((3 + 2*ID_BITS + 2*16 + 7) / 8) * 8;

  typedef struct packed {
    logic [TIME_BITS-1:0]  arrival;
    logic [PRIO_BITS-1:0]  prio;
    logic [BURST_BITS-1:0] burst;
    logic [BURST_BITS-1:0] remaining;
    logic [ID_BITS-1:0]    id;
  } entry_t;

  typedef struct packed {
    logic [STAT_BITS-1:0] turnaround_time;
    logic [STAT_BITS-1:0] wait_time;
    logic [ID_BITS-1:0]   finished_id;
    logic                 finished;
    logic [ID_BITS-1:0]   running_id;
    logic                 busy_res;
    logic                 rejected;
  } result_t;

  // configuration registers
  logic key_select_q, preempt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_select_q <= 1'b0;
      preempt_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_KEY_SELECT: key_select_q <= cfg_wdata_i;
        REG_PREEMPT:    preempt_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control state
  state_e                state_q, state_d;
  logic [SLOTS-1:0]      valid_q, valid_d;
  logic [AW-1:0]         cur_slot_q, cur_slot_d;
  logic                  cur_valid_q, cur_valid_d;
  logic                  cur_ok_q, cur_ok_d;
  logic [TIME_BITS-1:0]  time_q, time_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic                  eval_vld_q, eval_vld_d;
  logic [AW-1:0]         eval_idx_q, eval_idx_d;
  logic                  found_q, found_d;
  logic                  m_valid_q, m_valid_d;

  // payload registers
  entry_t                in_q, in_d;
  entry_t                best_q, best_d;
  logic [KEY_BITS-1:0]   best_key_q, best_key_d;
  logic [AW-1:0]         pick_q, pick_d;
  logic [TIME_BITS-1:0]  turn_q, turn_d;
  result_t               res_q, res_d;
  result_t               out_q, out_d;

  // slot memory
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  entry_t                wr_data;
  logic [AW-1:0]         rd_addr;
  entry_t                rd_data;

  jssp_slot_ram #(
    .DEPTH (SLOTS),
    .WIDTH ($bits(entry_t))
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // shared key comparator
  logic [KEY_BITS-1:0]   scan_key;
  logic                  key_less, key_equal;
  logic                  in_accept;
  logic [TIME_BITS:0]    wait_diff;
  logic [TIME_BITS-1:0]  wait_val;

  assign scan_key  = key_select_q ? KEY_BITS'(rd_data.prio) : KEY_BITS'(rd_data.remaining);
  assign key_less  = scan_key < best_key_q;
  assign key_equal = scan_key == best_key_q;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // wait time with borrow, clamped at zero
  assign wait_diff = {1'b0, turn_q} - (TIME_BITS+1)'(best_q.burst);
  assign wait_val  = wait_diff[TIME_BITS] ? '0 : wait_diff[TIME_BITS-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'(out_q);

  // sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    cur_slot_d  = cur_slot_q;
    cur_valid_d = cur_valid_q;
    cur_ok_d    = cur_ok_q;
    time_d      = time_q;
    idx_d       = idx_q;
    eval_vld_d  = 1'b0;
    eval_idx_d  = idx_q[AW-1:0];
    found_d     = found_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    in_d        = in_q;
    best_d      = best_q;
    best_key_d  = best_key_q;
    pick_d      = pick_q;
    turn_d      = turn_q;
    res_d       = res_q;
    out_d       = out_q;
    wr_en       = 1'b0;
    wr_addr     = idx_q[AW-1:0];
    wr_data     = in_q;
    rd_addr     = idx_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          res_d           = '0;
          idx_d           = '0;
          found_d         = 1'b0;
          in_d.id         = s_axis_tdata[ID_BITS-1:0];
          in_d.burst      = s_axis_tdata[ID_BITS +: BURST_BITS];
          in_d.remaining  = s_axis_tdata[ID_BITS +: BURST_BITS];
          in_d.prio       = s_axis_tdata[ID_BITS+BURST_BITS +: PRIO_BITS];
          in_d.arrival    = time_q;
          if (s_axis_tuser == REQ_ARRIVAL) begin
            state_d = ST_FREE_SCAN;
          end else begin
            // time advances at every tick
            time_d   = time_q + 1'b1;
            cur_ok_d = cur_valid_q && valid_q[cur_slot_q];
            if (cur_valid_q && valid_q[cur_slot_q] && !preempt_q) begin
              state_d = ST_CUR_READ;
            end else begin
              state_d = ST_TICK_SCAN;
            end
          end
        end
      end

      // lowest free slot, one slot a cycle
      ST_FREE_SCAN: begin
        if (idx_q == IW'(SLOTS)) begin
          res_d.rejected = 1'b1;
          state_d        = ST_RESULT;
        end else if (!valid_q[idx_q[AW-1:0]]) begin
          wr_en                  = 1'b1;
          valid_d[idx_q[AW-1:0]] = 1'b1;
          state_d                = ST_RESULT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // read slot idx while judging the slot read in the previous cycle
      ST_TICK_SCAN: begin
        if (eval_vld_q && valid_q[eval_idx_q] &&
            (!found_q || key_less ||
             (key_equal && cur_ok_q && eval_idx_q == cur_slot_q))) begin
          found_d    = 1'b1;
          pick_d     = eval_idx_q;
          best_key_d = scan_key;
          best_d     = rd_data;
        end
        if (idx_q == IW'(SLOTS)) begin
          state_d = ST_PICKED;
        end else begin
          idx_d      = idx_q + 1'b1;
          eval_vld_d = 1'b1;
        end
      end

      // running job keeps the slot
      ST_CUR_READ: begin
        rd_addr = cur_slot_q;
        state_d = ST_CUR_CAP;
      end

      ST_CUR_CAP: begin
        best_d  = rd_data;
        pick_d  = cur_slot_q;
        state_d = ST_UPDATE;
      end

      ST_PICKED: begin
        if (found_q) begin
          state_d = ST_UPDATE;
        end else begin
          cur_valid_d = 1'b0;
          state_d     = ST_RESULT;
        end
      end

      // run the picked job for one unit
      ST_UPDATE: begin
        res_d.busy_res   = 1'b1;
        res_d.running_id = best_q.id;
        cur_slot_d       = pick_q;
        if (best_q.remaining < BURST_BITS'(2)) begin
          valid_d[pick_q]   = 1'b0;
          cur_valid_d       = 1'b0;
          res_d.finished    = 1'b1;
          res_d.finished_id = best_q.id;
          turn_d            = time_q - best_q.arrival;
          state_d           = ST_WAIT;
        end else begin
          cur_valid_d       = 1'b1;
          wr_en             = 1'b1;
          wr_addr           = pick_q;
          wr_data           = best_q;
          wr_data.remaining = best_q.remaining - 1'b1;
          state_d           = ST_RESULT;
        end
      end

      // saturate the statistics
      ST_WAIT: begin
        res_d.wait_time = (|wait_val[TIME_BITS-1:STAT_BITS]) ?
                          '1 : wait_val[STAT_BITS-1:0];
        res_d.turnaround_time = (|turn_q[TIME_BITS-1:STAT_BITS]) ?
                                '1 : turn_q[STAT_BITS-1:0];
        state_d = ST_RESULT;
      end

      // hand the result over once the output register is free
      ST_RESULT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_d     = res_q;
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      cur_slot_q  <= '0;
      cur_valid_q <= 1'b0;
      cur_ok_q    <= 1'b0;
      time_q      <= '0;
      idx_q       <= '0;
      eval_vld_q  <= 1'b0;
      eval_idx_q  <= '0;
      found_q     <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      cur_slot_q  <= cur_slot_d;
      cur_valid_q <= cur_valid_d;
      cur_ok_q    <= cur_ok_d;
      time_q      <= time_d;
      idx_q       <= idx_d;
      eval_vld_q  <= eval_vld_d;
      eval_idx_q  <= eval_idx_d;
      found_q     <= found_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    in_q       <= in_d;
    best_q     <= best_d;
    best_key_q <= best_key_d;
    pick_q     <= pick_d;
    turn_q     <= turn_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

endmodule
